[rtl/tcg_pkg.sv]
`timescale 1ns / 1ps

package tcg_pkg;

  // Gesture codes carried by each result transaction.
  localparam logic [1:0] GEST_NONE   = 2'd0;
  localparam logic [1:0] GEST_CLICK  = 2'd1;
  localparam logic [1:0] GEST_DOUBLE = 2'd2;
  localparam logic [1:0] GEST_LONG   = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SLOP = 2'd2;

  // Register reset values.
  localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [15:0] DOUBLE_GAP_RST = 16'd300;
  localparam logic [14:0] DOUBLE_SLOP_RST = 15'd30;

  // Configuration values as seen by the detector.
  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] double_gap_ms;
    logic [14:0] double_slop;
  } cfg_t;

  // One touch report or idle poll.
  typedef struct packed {
    logic               report_valid;
    logic               pressed;
    logic [3:0]         point_count;
    logic [31:0]        report_time;
    logic [31:0]        now_time;
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_y;
    logic [14:0]        widget_width;
    logic [14:0]        widget_height;
    logic               has_active;
    logic               move_consumed;
    logic               restart;
  } item_t;

endpackage

[rtl/tcg_if.sv]
`timescale 1ns / 1ps

// Input channel: touch reports and idle polls.
interface tcg_item_if;
  logic               valid;
  logic               ready;
  logic               report_valid;
  logic               pressed;
  logic [3:0]         point_count;
  logic [31:0]        report_time;
  logic [31:0]        now_time;
  logic signed [15:0] rel_x;
  logic signed [15:0] rel_y;
  logic [14:0]        widget_width;
  logic [14:0]        widget_height;
  logic               has_active;
  logic               move_consumed;
  logic               restart;

  modport source (
    output valid, report_valid, pressed, point_count, report_time, now_time,
           rel_x, rel_y, widget_width, widget_height, has_active, move_consumed,
           restart,
    input  ready
  );
  modport sink (
    input  valid, report_valid, pressed, point_count, report_time, now_time,
           rel_x, rel_y, widget_width, widget_height, has_active, move_consumed,
           restart,
    output ready
  );
endinterface

// Output channel: one gesture code per item.
interface tcg_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;

  modport source (output valid, gesture, input ready);
  modport sink (input valid, gesture, output ready);
endinterface

// Configuration write channel.
interface tcg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcg_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tcg_cfg_regs.sv]
`timescale 1ns / 1ps

module tcg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tcg_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]                   wr_data,
  output tcg_pkg::cfg_t                 cfg
);

  tcg_pkg::cfg_t regs;

  // Register file; writes to an unknown index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.long_press_ms <= tcg_pkg::LONG_PRESS_RST;
      regs.double_gap_ms <= tcg_pkg::DOUBLE_GAP_RST;
      regs.double_slop   <= tcg_pkg::DOUBLE_SLOP_RST;
    end else if (wr_en) begin
      case (wr_index)
        tcg_pkg::CFG_LONG_PRESS:  regs.long_press_ms <= wr_data;
        tcg_pkg::CFG_DOUBLE_GAP:  regs.double_gap_ms <= wr_data;
        tcg_pkg::CFG_DOUBLE_SLOP: regs.double_slop   <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

[rtl/tcg_fsm.sv]
`timescale 1ns / 1ps

module tcg_fsm (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  tcg_pkg::item_t item,
  input  tcg_pkg::cfg_t  cfg,
  output logic [1:0]     gesture_next
);

  // Detector phases.
  localparam logic [1:0] PH_EDGE = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  logic [1:0]  phase, phase_next;
  logic        tap_index, tap_index_next;
  logic [31:0] mark_time, mark_time_next;
  logic [15:0] first_x, first_x_next, first_y, first_y_next;
  logic [15:0] second_x, second_x_next, second_y, second_y_next;
  logic        last_pressed, last_pressed_next;

  logic [31:0] elapsed;
  logic        long_expired, gap_expired;
  logic        press_edge;
  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;
  logic        too_far, off_widget;

  // Elapsed time since the mark, modulo 2^32.
  assign elapsed      = item.now_time - mark_time;
  assign long_expired = elapsed > {16'd0, cfg.long_press_ms};
  assign gap_expired  = elapsed > {16'd0, cfg.double_gap_ms};
  assign press_edge   = item.report_valid && item.pressed && !last_pressed &&
                        (item.point_count == 4'd1);

  // Per-axis distance between the two recorded taps.
  assign dx  = {first_x[15], first_x} - {second_x[15], second_x};
  assign dy  = {first_y[15], first_y} - {second_y[15], second_y};
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign too_far = (adx > {2'b00, cfg.double_slop}) || (ady > {2'b00, cfg.double_slop});

  // A recorded tap lies outside when negative or beyond the widget size.
  assign off_widget =
      first_x[15]  || (first_x[14:0]  > item.widget_width)  ||
      first_y[15]  || (first_y[14:0]  > item.widget_height) ||
      second_x[15] || (second_x[14:0] > item.widget_width)  ||
      second_y[15] || (second_y[14:0] > item.widget_height);

  // Next state and gesture for the item on the input.  A restart clears the
  // sequence first; the release checks use the registered positions since a
  // restart always leads to the press-edge branch.
  always_comb begin
    phase_next        = phase;
    tap_index_next    = tap_index;
    mark_time_next    = mark_time;
    first_x_next      = first_x;
    first_y_next      = first_y;
    second_x_next     = second_x;
    second_y_next     = second_y;
    last_pressed_next = item.report_valid ? item.pressed : last_pressed;
    gesture_next      = tcg_pkg::GEST_NONE;

    if (item.restart) begin
      phase_next     = PH_EDGE;
      tap_index_next = 1'b0;
      first_x_next   = '0;
      first_y_next   = '0;
      second_x_next  = '0;
      second_y_next  = '0;
    end

    if (!item.report_valid || item.has_active) begin
      case (phase_next)
        PH_HOLD: begin
          if (item.report_valid) begin
            if (item.pressed && !item.move_consumed) begin
              // Unconsumed move refreshes time and position of this tap.
              mark_time_next = item.report_time;
              if (!tap_index) begin
                first_x_next = item.rel_x;
                first_y_next = item.rel_y;
              end else begin
                second_x_next = item.rel_x;
                second_y_next = item.rel_y;
              end
            end else if (!item.pressed) begin
              // Release: click, double click or nothing.
              if (off_widget) begin
                phase_next     = PH_EDGE;
                tap_index_next = 1'b0;
                first_x_next   = '0;
                first_y_next   = '0;
                second_x_next  = '0;
                second_y_next  = '0;
              end else if (!tap_index || too_far) begin
                tap_index_next = 1'b0;
                mark_time_next = item.report_time;
                phase_next     = PH_GAP;
                gesture_next   = tcg_pkg::GEST_CLICK;
              end else begin
                phase_next     = PH_EDGE;
                tap_index_next = 1'b0;
                first_x_next   = '0;
                first_y_next   = '0;
                second_x_next  = '0;
                second_y_next  = '0;
                gesture_next   = tcg_pkg::GEST_DOUBLE;
              end
            end else if (tap_index) begin
              // Consumed move on the second tap ends the sequence.
              phase_next     = PH_EDGE;
              tap_index_next = 1'b0;
              first_x_next   = '0;
              first_y_next   = '0;
              second_x_next  = '0;
              second_y_next  = '0;
            end else begin
              // Consumed move on the first tap: look for the second press.
              tap_index_next = 1'b1;
              phase_next     = PH_EDGE;
              if (press_edge) begin
                mark_time_next = item.report_time;
                second_x_next  = item.rel_x;
                second_y_next  = item.rel_y;
                phase_next     = PH_HOLD;
              end
            end
          end else if (long_expired) begin
            // Held too long: long click on the first tap only.
            gesture_next   = tap_index ? tcg_pkg::GEST_NONE : tcg_pkg::GEST_LONG;
            phase_next     = PH_EDGE;
            tap_index_next = 1'b0;
            first_x_next   = '0;
            first_y_next   = '0;
            second_x_next  = '0;
            second_y_next  = '0;
          end
        end
        PH_GAP: begin
          if (gap_expired || tap_index) begin
            phase_next     = PH_EDGE;
            tap_index_next = 1'b0;
            first_x_next   = '0;
            first_y_next   = '0;
            second_x_next  = '0;
            second_y_next  = '0;
          end else if (item.report_valid && item.pressed) begin
            tap_index_next = 1'b1;
            phase_next     = PH_EDGE;
            if (press_edge) begin
              mark_time_next = item.report_time;
              second_x_next  = item.rel_x;
              second_y_next  = item.rel_y;
              phase_next     = PH_HOLD;
            end
          end
        end
        default: begin
          // Waiting for a single-point press edge.
          if (phase_next != PH_EDGE) begin
            tap_index_next = 1'b0;
            first_x_next   = '0;
            first_y_next   = '0;
            second_x_next  = '0;
            second_y_next  = '0;
          end
          phase_next = PH_EDGE;
          if (press_edge) begin
            mark_time_next = item.report_time;
            phase_next     = PH_HOLD;
            if (!tap_index_next) begin
              first_x_next = item.rel_x;
              first_y_next = item.rel_y;
            end else begin
              second_x_next = item.rel_x;
              second_y_next = item.rel_y;
            end
          end
        end
      endcase
    end
  end

  // State registers, updated once per accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_EDGE;
      tap_index    <= 1'b0;
      mark_time    <= '0;
      first_x      <= '0;
      first_y      <= '0;
      second_x     <= '0;
      second_y     <= '0;
      last_pressed <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      tap_index    <= tap_index_next;
      mark_time    <= mark_time_next;
      first_x      <= first_x_next;
      first_y      <= first_y_next;
      second_x     <= second_x_next;
      second_y     <= second_y_next;
      last_pressed <= last_pressed_next;
    end
  end

endmodule

[rtl/touch_click_gesture_detector_top.sv]
`timescale 1ns / 1ps

// Touch click gesture detector.
//
// The item channel carries touch reports (report_valid high) and idle polls
// (report_valid low) for the active widget. Each accepted transaction yields
// exactly one transaction on the result channel with a gesture code: none,
// click, double click or long click. Idle polls let held presses and the
// double-click gap time out against now_time.
// The cfg channel writes the long-press time, double-click gap and slop;
// it is always ready and should be used only while no result is pending.
// The result of an item accepted at one clock edge is registered and offered
// from the next. Throughput is one item per cycle, set by the single
// output register; the detector state updates in the same cycle.
// If the receiver stalls, the pending result is held and one more item is
// taken only in a cycle where the pending result leaves.
// Reset (rst, synchronous) empties the output register, returns the
// detector to waiting for a first press and restores register defaults.

module touch_click_gesture_detector_top (
  input logic          clk,
  input logic          rst,
  tcg_item_if.sink     item,
  tcg_result_if.source result,
  tcg_cfg_if.sink      cfg
);

  tcg_pkg::item_t item_data;
  tcg_pkg::cfg_t  cfg_values;
  logic           item_accept;
  logic [1:0]     gesture_next;
  logic           out_valid;
  logic [1:0]     out_gesture;

  // Bundle the input payload.
  assign item_data.report_valid  = item.report_valid;
  assign item_data.pressed       = item.pressed;
  assign item_data.point_count   = item.point_count;
  assign item_data.report_time   = item.report_time;
  assign item_data.now_time      = item.now_time;
  assign item_data.rel_x         = item.rel_x;
  assign item_data.rel_y         = item.rel_y;
  assign item_data.widget_width  = item.widget_width;
  assign item_data.widget_height = item.widget_height;
  assign item_data.has_active    = item.has_active;
  assign item_data.move_consumed = item.move_consumed;
  assign item_data.restart       = item.restart;

  // Accept while the output register is empty or being emptied.
  assign item.ready  = !out_valid || result.ready;
  assign item_accept = item.valid && item.ready;
  assign cfg.ready   = 1'b1;

  tcg_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_values)
  );

  tcg_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .accept       (item_accept),
    .item         (item_data),
    .cfg          (cfg_values),
    .gesture_next (gesture_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      out_gesture <= gesture_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.gesture = out_gesture;

endmodule
